### sv/nss_pkg.sv
// shared types and constants for the brute-force substring search block
// no dependencies; imported by the top level and its checker

package nss_pkg;

   // request modes
   localparam logic [1:0] MODE_TEXT    = 2'd0;
   localparam logic [1:0] MODE_PATTERN = 2'd1;
   localparam logic [1:0] MODE_SEARCH  = 2'd2;

   localparam int POS_W = 7;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] match_position;
      logic             overflowed;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } search_state_type;

endpackage

### sv/naive_substring_search.sv
// brute-force substring search: text and pattern loaded a character per beat into
// two synchronous memories, one compare step per cycle; uses nss_pkg
// appends are registered into the memories and lengths; a search beat gives its result
// beat after its compare steps (at most about text_len * pattern_len), from a result register
// throughput: one append per cycle; no beat is taken while a search runs
// reset: synchronous, clears lengths, overflow flag, state and result valid;
// memory contents are not cleared and are only read below the written length

module naive_substring_search #(
   parameter int MAX_LEN = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nss_pkg::rsp_type rsp_data
);
   import nss_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // character stores, one write port (append) and one registered read port each
   logic [7:0] text_mem [MAX_LEN];
   logic [7:0] pat_mem  [MAX_LEN];
   logic [7:0] text_rd_ff;
   logic [7:0] pat_rd_ff;

   search_state_type state_ff, state_in;

   logic [LEN_W-1:0] tlen_ff, tlen_in;
   logic [LEN_W-1:0] plen_ff, plen_in;
   logic             ovf_ff, ovf_in;
   // search cursors: text index and pattern index
   logic [LEN_W-1:0] ti_ff, ti_in;
   logic [LEN_W-1:0] pj_ff, pj_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire;
   logic search_live;
   logic rsp_free;
   logic text_wr;
   logic pat_wr;

   assign req_fire    = req_valid && !req_stall;
   // loop runs while both cursors are inside their strings
   assign search_live = (ti_ff < tlen_ff) && (pj_ff < plen_ff);
   // result register can take a new beat this cycle
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.mode == MODE_SEARCH) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (!search_live && rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = 1'b1;
      text_wr      = 1'b0;
      pat_wr       = 1'b0;
      ti_in        = ti_ff;
      pj_in        = pj_ff;
      tlen_in      = tlen_ff;
      plen_in      = plen_ff;
      ovf_in       = ovf_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            // cursors start at zero so the first reads are in flight on entry
            ti_in     = '0;
            pj_in     = '0;
            if (req_fire) begin
               priority if (req_data.mode == MODE_TEXT) begin
                  if (tlen_ff < LEN_W'(MAX_LEN)) begin
                     text_wr = 1'b1;
                     tlen_in = tlen_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (req_data.mode == MODE_PATTERN) begin
                  if (plen_ff < LEN_W'(MAX_LEN)) begin
                     pat_wr  = 1'b1;
                     plen_in = plen_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  // search starts next cycle; unused mode does nothing
               end
            end
         end
         ST_SEARCH: begin
            if (search_live) begin
               if (text_rd_ff == pat_rd_ff) begin
                  ti_in = ti_ff + LEN_W'(1);
                  pj_in = pj_ff + LEN_W'(1);
               end else begin
                  // back up to one past the start of this attempt
                  ti_in = ti_ff - pj_ff + LEN_W'(1);
                  pj_in = '0;
               end
            end else if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.found          = (pj_ff == plen_ff);
               rsp_data_in.match_position = (pj_ff == plen_ff)
                                            ? POS_W'(ti_ff - plen_ff) : '0;
               rsp_data_in.overflowed     = ovf_ff;
               tlen_in                    = '0;
               plen_in                    = '0;
               ovf_in                     = 1'b0;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // memories: append writes, reads addressed by next cursor values
   always_ff @(posedge clock) begin
      if (text_wr) begin
         text_mem[tlen_ff[IDX_W-1:0]] <= req_data.char_in;
      end
      if (pat_wr) begin
         pat_mem[plen_ff[IDX_W-1:0]] <= req_data.char_in;
      end
      text_rd_ff <= text_mem[ti_in[IDX_W-1:0]];
      pat_rd_ff  <= pat_mem[pj_in[IDX_W-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tlen_ff      <= '0;
         plen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tlen_ff      <= tlen_in;
         plen_ff      <= plen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ti_ff       <= ti_in;
      pj_ff       <= pj_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/nss_checker.sv
// port-level checks for the brute-force substring search block
// uses nss_pkg; bound to naive_substring_search

module nss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input nss_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input nss_pkg::rsp_type rsp_data
);
   import nss_pkg::*;

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // no match reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.match_position == '0)
      else $error("miss with nonzero position");

   // a search beat keeps the input side busy in the next cycle
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode == MODE_SEARCH |=> req_stall)
      else $error("input taken right after a search beat");

   // a new result only appears at the end of a search
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without a running search");

endmodule

bind naive_substring_search nss_checker u_nss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/tb_naive_substring_search.sv
// self-checking testbench for naive_substring_search: directed and random text, pattern and search beats
// checked against a brute-force match scoreboard kept in the testbench
// depends on nss_pkg and naive_substring_search

`timescale 1ns / 1ps

module tb_naive_substring_search;
   import nss_pkg::*;

   localparam int unsigned STORE_DEPTH = 128;
   localparam logic [1:0]  MODE_UNUSED = 2'd3;     // reserved mode, block ignores it
   localparam logic [7:0]  CHAR_A      = 8'h61;
   localparam int unsigned ITEM_TARGET = 900;
   localparam int unsigned HOLD_CYCLES = 400;      // long receiver hold-off
   localparam int unsigned IDLE_LIMIT  = 60000;    // longest search plus stalls, several times
   localparam int unsigned DRAIN_CYCLES = 40;

   // expected results of searches, from a private copy of both stores
   class match_book;
      logic [7:0]  text_mem [STORE_DEPTH];
      logic [7:0]  pattern_mem [STORE_DEPTH];
      int unsigned text_len = 0;
      int unsigned pattern_len = 0;
      logic        overflow_seen = 1'b0;
      rsp_type     expected_results [$];
      int unsigned errors = 0;
      int unsigned beats = 0;
      int unsigned searches = 0;
      int unsigned hits = 0;
      int unsigned dropped = 0;
      int unsigned ignored = 0;

      task report(input string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      // backtracking scan, first occurrence wins
      function rsp_type predict_search();
         int unsigned ti;
         int unsigned pj;
         rsp_type     r;
         ti = 0;
         pj = 0;
         while (ti < text_len && pj < pattern_len) begin
            if (text_mem[ti] == pattern_mem[pj]) begin
               ti++;
               pj++;
            end else begin
               ti = ti - pj + 1;
               pj = 0;
            end
         end
         r.overflowed = overflow_seen;
         if (pj == pattern_len) begin
            r.found          = 1'b1;
            r.match_position = POS_W'(ti - pattern_len);
         end else begin
            r.found          = 1'b0;
            r.match_position = '0;
         end
         return r;
      endfunction

      task note_request(input req_type b);
         beats++;
         case (b.mode)
            MODE_TEXT: begin
               if (text_len < STORE_DEPTH) begin
                  text_mem[text_len] = b.char_in;
                  text_len++;
               end else begin
                  overflow_seen = 1'b1;
               end
            end
            MODE_PATTERN: begin
               if (pattern_len < STORE_DEPTH) begin
                  pattern_mem[pattern_len] = b.char_in;
                  pattern_len++;
               end else begin
                  overflow_seen = 1'b1;
               end
            end
            MODE_SEARCH: begin
               expected_results.push_back(predict_search());
               searches++;
               text_len      = 0;
               pattern_len   = 0;
               overflow_seen = 1'b0;
            end
            default: begin
               ignored++;
            end
         endcase
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report("result beat with no search waiting");
            return;
         end
         want = expected_results.pop_front();
         if (want.found) hits++;
         if (want.overflowed) dropped++;
         if (got.found !== want.found)
            report($sformatf("found got %0b want %0b", got.found, want.found));
         if (got.match_position !== want.match_position)
            report($sformatf("match_position got %0d want %0d",
                             got.match_position, want.match_position));
         if (got.overflowed !== want.overflowed)
            report($sformatf("overflowed got %0b want %0b", got.overflowed, want.overflowed));
      endtask

      function int unsigned pending();
         return expected_results.size();
      endfunction

      task close_out();
         while (expected_results.size() != 0) begin
            void'(expected_results.pop_front());
            report("search result never arrived");
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   match_book   book;
   int unsigned beats_sent = 0;     // counted beats, ignored mode left out
   int unsigned hold_requests = 0;  // bumped by the stimulus, served by the result sink
   bit          no_idle = 1'b0;     // stretch with no gaps on either side

   always #6 clock = ~clock;

   naive_substring_search #(.MAX_LEN(STORE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // monitor: every accepted beat is seen at the edge, before our own drives land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) book.note_request(req_data);
         if (rsp_valid && !rsp_stall) book.check_result(rsp_data);
      end
   end

   // watchdog: any beat on either channel restarts the count
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("no beat moved for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // result sink: random stalls, a quiet stretch, and one long hold-off on request
   initial begin : result_sink
      int unsigned hold_left;
      int unsigned hold_served;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 32);
         end
      end
   end

   // 0 means any byte, otherwise letters from 'a' on
   function automatic logic [7:0] pick_char(input int unsigned alpha);
      if (alpha == 0) return 8'($urandom_range(255));
      return 8'(CHAR_A + $urandom_range(alpha - 1));
   endfunction

   // small alphabets make hits and partial matches common
   function automatic int unsigned pick_alphabet();
      case ($urandom_range(4))
         0:       return 1;
         1, 2:    return 2;
         3:       return 3;
         default: return ($urandom_range(1) == 0) ? 26 : 0;
      endcase
   endfunction

   // one beat, with a random gap first; valid stays up into the next beat if no gap
   task automatic send_beat(input logic [1:0] mode, input logic [7:0] ch);
      req_type b;
      b.mode    = mode;
      b.char_in = ch;
      while (!no_idle && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode != MODE_UNUSED) beats_sent++;
   endtask

   task automatic load_chars(input logic [1:0] mode, input string s);
      for (int i = 0; i < s.len(); i++) send_beat(mode, s[i]);
   endtask

   // text and pattern in one of three orders, then the search beat;
   // the pattern is often cut from the text so that hits are common
   task automatic run_sequence(input int unsigned text_n, input int unsigned pattern_n,
                               input int unsigned alpha);
      logic [7:0]  text_q [$];
      logic [7:0]  pattern_q [$];
      int unsigned start;
      int unsigned span;
      int unsigned order;
      int unsigned ti;
      int unsigned pj;
      for (int unsigned i = 0; i < text_n; i++) text_q.push_back(pick_char(alpha));
      if (text_n != 0 && $urandom_range(99) < 40) begin
         start = $urandom_range(text_n - 1);
         span  = $urandom_range(1, (text_n - start < 6) ? text_n - start : 6);
         for (int unsigned i = 0; i < span; i++) pattern_q.push_back(text_q[start + i]);
      end else begin
         for (int unsigned i = 0; i < pattern_n; i++) pattern_q.push_back(pick_char(alpha));
      end
      order = $urandom_range(2);
      ti = 0;
      pj = 0;
      while (ti < text_q.size() || pj < pattern_q.size()) begin
         if (pj == pattern_q.size() || (ti < text_q.size() &&
             (order == 0 || (order == 2 && $urandom_range(1) == 0)))) begin
            send_beat(MODE_TEXT, text_q[ti]);
            ti++;
         end else begin
            send_beat(MODE_PATTERN, pattern_q[pj]);
            pj++;
         end
      end
      send_beat(MODE_SEARCH, pick_char(0));
   endtask

   initial begin : stimulus
      int unsigned pick;
      bit          pressure_done;
      pressure_done = 1'b0;
      book = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty text and pattern
      send_beat(MODE_SEARCH, 8'h00);
      // extreme bytes, reserved mode in between, hit at one
      send_beat(MODE_TEXT, 8'hff);
      send_beat(MODE_TEXT, 8'h00);
      send_beat(MODE_PATTERN, 8'h00);
      send_beat(MODE_UNUSED, 8'hff);
      send_beat(MODE_SEARCH, 8'hff);
      // mismatch after a partial match, text position falls back
      load_chars(MODE_TEXT, "aab");
      load_chars(MODE_PATTERN, "ab");
      send_beat(MODE_SEARCH, 8'h00);
      // pattern longer than text
      load_chars(MODE_TEXT, "a");
      load_chars(MODE_PATTERN, "ab");
      send_beat(MODE_SEARCH, 8'h00);
      // empty pattern on a non-empty text
      load_chars(MODE_TEXT, "xy");
      send_beat(MODE_SEARCH, 8'h00);
      // pattern loaded before the text, no hit
      load_chars(MODE_PATTERN, "q");
      load_chars(MODE_TEXT, "z");
      send_beat(MODE_SEARCH, 8'h00);

      // text store past full, and mostly the pattern store too, so characters are dropped
      run_sequence(STORE_DEPTH + 2, STORE_DEPTH + 1, 2);

      while (beats_sent < ITEM_TARGET) begin
         if (!pressure_done && beats_sent >= 300) begin
            hold_requests++;
            pressure_done = 1'b1;
         end
         no_idle = (beats_sent >= 500 && beats_sent < 650);
         pick = $urandom_range(99);
         if (pick < 70) begin
            run_sequence($urandom_range(12), $urandom_range(4), pick_alphabet());
         end else if (pick < 73) begin
            // long text, now and then a long pattern too
            run_sequence($urandom_range(100, STORE_DEPTH),
                         ($urandom_range(3) == 0) ? $urandom_range(100, STORE_DEPTH)
                                                   : $urandom_range(1, 12),
                         pick_alphabet());
         end else if (pick < 75) begin
            run_sequence($urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 8),
                         ($urandom_range(1) == 0) ? $urandom_range(3)
                                                   : $urandom_range(STORE_DEPTH - 1,
                                                                    STORE_DEPTH + 4),
                         pick_alphabet());
         end else begin
            // noise: loose beats in any mode
            repeat ($urandom_range(1, 6))
               send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      // let the monitor note the last beat, then drain outstanding searches
      // and watch for stray result beats
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      book.close_out();

      $display("run covered %0d request beats: %0d searches, %0d hits, %0d with dropped chars,",
               book.beats, book.searches, book.hits, book.dropped);
      $display("%0d beats in the reserved mode, plus a %0d-cycle hold-off on the results",
               book.ignored, HOLD_CYCLES);
      if (book.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### filelist.f
sv/nss_pkg.sv
sv/naive_substring_search.sv
sv/nss_checker.sv
tb/tb_naive_substring_search.sv
